// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the checker. They expect clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante |-> cons, sampled on clk, off while reset is asserted
`define ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// ante |=> cons, sampled on clk, off while reset is asserted
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/bqd_pkg.sv -----
// ----------------------------------------------------------------------------
// bqd_pkg
// Widths, command/status types and saturation helpers for the biquad core.
// ----------------------------------------------------------------------------
`default_nettype none

package bqd_pkg;

	localparam int SAMPLE_WIDTH    = 24;
	localparam int COEF_WIDTH      = 24;
	localparam int STATE_WIDTH     = 32;
	localparam int COEF_FRAC       = COEF_WIDTH - 2;
	localparam int PROD_WIDTH      = COEF_WIDTH + STATE_WIDTH;
	// three products plus the rounding half, or two products plus the input term, need two guard bits
	localparam int ACC_WIDTH       = PROD_WIDTH + 2;
	localparam int SUM_WIDTH       = ACC_WIDTH - COEF_FRAC;
	localparam int NUM_REGS        = 5;
	localparam int CFG_INDEX_WIDTH = $clog2(NUM_REGS);

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_FEEDBACK_ONE = CFG_INDEX_WIDTH'(0),
		REG_FEEDBACK_TWO = CFG_INDEX_WIDTH'(1),
		REG_FORWARD_ZERO = CFG_INDEX_WIDTH'(2),
		REG_FORWARD_ONE  = CFG_INDEX_WIDTH'(3),
		REG_FORWARD_TWO  = CFG_INDEX_WIDTH'(4)
	} reg_index_t;

	// multiplier operand pair
	typedef enum logic [2:0] {
		MUL_A1 = 3'd0,
		MUL_A2 = 3'd1,
		MUL_B0 = 3'd2,
		MUL_B1 = 3'd3,
		MUL_B2 = 3'd4
	} mul_sel_t;

	typedef enum logic [1:0] {
		ACC_HOLD = 2'd0,
		ACC_BASE = 2'd1,
		ACC_ADD  = 2'd2,
		ACC_HALF = 2'd3
	} acc_op_t;

	typedef struct packed {
		mul_sel_t mul_sel;
		acc_op_t  acc_op;
		logic     w_load;
		logic     y_load;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} status_t;

	typedef struct packed {
		logic signed [STATE_WIDTH-1:0] value;
		logic                          hit;
	} sat_state_t;

	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] value;
		logic                           hit;
	} sat_sample_t;

	function automatic sat_state_t sat_state(input logic signed [SUM_WIDTH-1:0] v);
		sat_state_t r;
		logic       fits;
		fits = (v[SUM_WIDTH-1:STATE_WIDTH-1] == '0) || (v[SUM_WIDTH-1:STATE_WIDTH-1] == '1);
		r.hit = !fits;
		if (fits) begin
			r.value = v[STATE_WIDTH-1:0];
		end else if (v[SUM_WIDTH-1]) begin
			r.value = {1'b1, {(STATE_WIDTH-1){1'b0}}};
		end else begin
			r.value = {1'b0, {(STATE_WIDTH-1){1'b1}}};
		end
		return r;
	endfunction

	function automatic sat_sample_t sat_sample(input logic signed [SUM_WIDTH-1:0] v);
		sat_sample_t r;
		logic        fits;
		fits = (v[SUM_WIDTH-1:SAMPLE_WIDTH-1] == '0) || (v[SUM_WIDTH-1:SAMPLE_WIDTH-1] == '1);
		r.hit = !fits;
		if (fits) begin
			r.value = v[SAMPLE_WIDTH-1:0];
		end else if (v[SUM_WIDTH-1]) begin
			r.value = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
		end else begin
			r.value = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/bqd_ctrl.sv -----
// ----------------------------------------------------------------------------
// bqd_ctrl
// Sequencer: walks the five products of one sample through the shared MAC.
// ----------------------------------------------------------------------------
`default_nettype none

module bqd_ctrl import bqd_pkg::*; (
	input  wire     clk,
	input  wire     arst_n,
	input  wire     in_valid,
	output logic    in_stall,
	input  status_t status,
	output cmd_t    cmd
);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_FB2  = 6'b000010,
		S_W    = 6'b000100,
		S_FF1  = 6'b001000,
		S_FF2  = 6'b010000,
		S_FF3  = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d     = state_q;
		cmd.mul_sel = MUL_A1;
		cmd.acc_op  = ACC_HOLD;
		cmd.w_load  = 1'b0;
		cmd.y_load  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				// a1*w1 and the input term start on the accept edge
				cmd.mul_sel = MUL_A1;
				cmd.acc_op  = ACC_BASE;
				if (in_valid) state_d = S_FB2;
			end
			S_FB2: begin
				cmd.mul_sel = MUL_A2;
				cmd.acc_op  = ACC_ADD;
				state_d     = S_W;
			end
			S_W: begin
				cmd.mul_sel = MUL_B1;
				cmd.acc_op  = ACC_HALF;
				cmd.w_load  = 1'b1;
				state_d     = S_FF1;
			end
			S_FF1: begin
				cmd.mul_sel = MUL_B2;
				cmd.acc_op  = ACC_ADD;
				state_d     = S_FF2;
			end
			S_FF2: begin
				cmd.mul_sel = MUL_B0;
				cmd.acc_op  = ACC_ADD;
				state_d     = S_FF3;
			end
			S_FF3: begin
				// keep b0*w in the product register while the output is blocked
				cmd.mul_sel = MUL_B0;
				cmd.y_load  = status.out_free;
				if (status.out_free) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/bqd_datapath.sv -----
// ----------------------------------------------------------------------------
// bqd_datapath
// Coefficient registers, delay line, shared multiplier, accumulator, output.
// ----------------------------------------------------------------------------
`default_nettype none

module bqd_datapath import bqd_pkg::*; (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_write_en,
	input  wire  [CFG_INDEX_WIDTH-1:0]     cfg_index,
	input  wire  [COEF_WIDTH-1:0]          cfg_data,
	input  wire  signed [SAMPLE_WIDTH-1:0] sample_in,
	input  cmd_t                           cmd,
	output status_t                        status,
	output logic                           out_valid,
	input  wire                            out_stall,
	output logic signed [SAMPLE_WIDTH-1:0] sample_out,
	output logic                           clipped
);

	localparam logic signed [ACC_WIDTH-1:0] ROUND_HALF = ACC_WIDTH'(1) << (COEF_FRAC - 1);

	logic signed [COEF_WIDTH-1:0]  a1_q, a2_q, b0_q, b1_q, b2_q;
	logic signed [STATE_WIDTH-1:0] w1_q, w2_q, w_q;
	logic                          hit_w_q;
	logic signed [PROD_WIDTH-1:0]  prod_q;
	logic signed [ACC_WIDTH-1:0]   acc_q;

	logic signed [COEF_WIDTH-1:0]  mul_coef;
	logic signed [STATE_WIDTH-1:0] mul_state;
	logic signed [ACC_WIDTH-1:0]   prod_ext;
	logic signed [ACC_WIDTH-1:0]   sum;
	logic signed [ACC_WIDTH-1:0]   base;
	logic signed [SUM_WIDTH-1:0]   sum_grid;
	sat_state_t                    w_sat;
	sat_sample_t                   y_sat;

	// configuration writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a1_q <= '0;
			a2_q <= '0;
			b0_q <= '0;
			b1_q <= '0;
			b2_q <= '0;
		end else if (cfg_write_en) begin
			unique case (reg_index_t'(cfg_index))
				REG_FEEDBACK_ONE: a1_q <= cfg_data;
				REG_FEEDBACK_TWO: a2_q <= cfg_data;
				REG_FORWARD_ZERO: b0_q <= cfg_data;
				REG_FORWARD_ONE:  b1_q <= cfg_data;
				REG_FORWARD_TWO:  b2_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cmd.mul_sel)
			MUL_A1: begin
				mul_coef  = a1_q;
				mul_state = w1_q;
			end
			MUL_A2: begin
				mul_coef  = a2_q;
				mul_state = w2_q;
			end
			MUL_B0: begin
				mul_coef  = b0_q;
				mul_state = w_q;
			end
			MUL_B1: begin
				mul_coef  = b1_q;
				mul_state = w1_q;
			end
			MUL_B2: begin
				mul_coef  = b2_q;
				mul_state = w2_q;
			end
			default: begin
				mul_coef  = '0;
				mul_state = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= PROD_WIDTH'(mul_coef) * PROD_WIDTH'(mul_state);
	end

	assign prod_ext = {{(ACC_WIDTH-PROD_WIDTH){prod_q[PROD_WIDTH-1]}}, prod_q};
	assign sum      = acc_q + prod_ext;
	// input sample lifted onto the product grid, with the rounding half folded in
	assign base     = ({{(ACC_WIDTH-SAMPLE_WIDTH){sample_in[SAMPLE_WIDTH-1]}}, sample_in}
		<<< COEF_FRAC) + ROUND_HALF;
	assign sum_grid = sum[ACC_WIDTH-1:COEF_FRAC];
	assign w_sat    = sat_state(sum_grid);
	assign y_sat    = sat_sample(sum_grid);

	always_ff @(posedge clk) begin
		case (cmd.acc_op)
			ACC_BASE: acc_q <= base;
			ACC_ADD:  acc_q <= sum;
			ACC_HALF: acc_q <= ROUND_HALF;
			default:  acc_q <= acc_q;
		endcase
		if (cmd.w_load) begin
			w_q     <= w_sat.value;
			hit_w_q <= w_sat.hit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w1_q <= '0;
			w2_q <= '0;
		end else if (cmd.y_load) begin
			w2_q <= w1_q;
			w1_q <= w_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.y_load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.y_load) begin
			sample_out <= y_sat.value;
			clipped    <= hit_w_q | y_sat.hit;
		end
	end

	assign status.out_free = !out_valid || !out_stall;

endmodule

`default_nettype wire

// ----- rtl/core/biquad_direct_form_two_core.sv -----
// ----------------------------------------------------------------------------
// biquad_direct_form_two_core
// Direct form II biquad with saturating Q9.23 state, one shared multiplier.
// ----------------------------------------------------------------------------
//  channel | signals                                   | handshake
//  --------+-------------------------------------------+------------------------
//  config  | cfg_write_en, cfg_index, cfg_data         | write on cfg_write_en
//  input   | in_valid, in_stall, sample_in             | valid && !stall
//  output  | out_valid, out_stall, sample_out, clipped | valid && !stall
//
//  The result is loaded into the output register after five MAC steps, one per
//  cycle except where the output stalls, all on a single 24x32 multiplier.
//  in_stall is high from the accept until the result is loaded into the output
//  register; a stalled output holds the last step until the register frees.
//  Reset clears coefficients, delay line and handshake state.
// ----------------------------------------------------------------------------
`default_nettype none

module biquad_direct_form_two_core import bqd_pkg::*; (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_write_en,
	input  wire  [CFG_INDEX_WIDTH-1:0]     cfg_index,
	input  wire  [COEF_WIDTH-1:0]          cfg_data,
	input  wire                            in_valid,
	output logic                           in_stall,
	input  wire  signed [SAMPLE_WIDTH-1:0] sample_in,
	output logic                           out_valid,
	input  wire                            out_stall,
	output logic signed [SAMPLE_WIDTH-1:0] sample_out,
	output logic                           clipped
);

	cmd_t    cmd;
	status_t status;

	bqd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	bqd_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sample_in    (sample_in),
		.cmd          (cmd),
		.status       (status),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.sample_out   (sample_out),
		.clipped      (clipped)
	);

endmodule

`default_nettype wire

// ----- rtl/core/bqd_checker.sv -----
// ----------------------------------------------------------------------------
// bqd_checker
// Port-level checks on the biquad core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bqd_checker import bqd_pkg::*; (
	input wire                           clk,
	input wire                           arst_n,
	input wire                           in_valid,
	input wire                           in_stall,
	input wire                           out_valid,
	input wire                           out_stall,
	input wire signed [SAMPLE_WIDTH-1:0] sample_out,
	input wire                           clipped
);

	`ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")
	`ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable({sample_out, clipped}), "stalled result changed")
	// the MAC sequence keeps the input closed after an accept while the item is in flight
	`ASSERT_NEXT(a_busy_span, in_valid && !in_stall, in_stall [*5], "input reopened mid-item")
	// a new result appears exactly as the core goes back to idle
	`ASSERT_IMPL(a_result_idle, $rose(out_valid), !in_stall, "result without finishing item")

endmodule

bind biquad_direct_form_two_core bqd_checker u_bqd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.sample_out (sample_out),
	.clipped    (clipped)
);

`default_nettype wire

// ----- verif/tb_biquad_direct_form_two_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_biquad_direct_form_two_core
// Self-checking bench for the direct form II biquad. A fixed-point predictor
// tracks the delay line and coefficients and works out every filtered sample
// and clip flag. Directed items cover silence, pass-through, rounding and
// saturation of state and output. Random filters and samples then run under
// changing back-pressure on both channels.
// ----------------------------------------------------------------------------
module tb_biquad_direct_form_two_core;
	import bqd_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 12;
	localparam int REPORT_LIMIT  = 10;
	localparam int ITEMS_PER_SET = 53;
	localparam int UNITY         = 1 << COEF_FRAC;

	localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
	localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
	localparam logic signed [COEF_WIDTH-1:0]   COEF_MAX   = {1'b0, {(COEF_WIDTH-1){1'b1}}};
	localparam logic signed [COEF_WIDTH-1:0]   COEF_MIN   = {1'b1, {(COEF_WIDTH-1){1'b0}}};
	localparam logic signed [COEF_WIDTH-1:0]   COEF_ONE   = COEF_WIDTH'(UNITY);
	localparam logic signed [COEF_WIDTH-1:0]   COEF_HALF  = COEF_WIDTH'(UNITY / 2);

	typedef struct {
		logic signed [SAMPLE_WIDTH-1:0] sample;
		logic                           clip;
	} filtered_t;

	logic                           clk          = 1'b0;
	logic                           arst_n       = 1'b0;
	logic                           cfg_write_en = 1'b0;
	logic [CFG_INDEX_WIDTH-1:0]     cfg_index    = '0;
	logic [COEF_WIDTH-1:0]          cfg_data     = '0;
	logic                           in_valid     = 1'b0;
	logic                           in_stall;
	logic signed [SAMPLE_WIDTH-1:0] sample_in    = '0;
	logic                           out_valid;
	logic                           out_stall    = 1'b0;
	logic signed [SAMPLE_WIDTH-1:0] sample_out;
	logic                           clipped;

	biquad_direct_form_two_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sample_in    (sample_in),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.sample_out   (sample_out),
		.clipped      (clipped)
	);

	// predictor state: coefficients and the two delayed w values
	logic signed [COEF_WIDTH-1:0]  coef_model [NUM_REGS];
	logic signed [STATE_WIDTH-1:0] w_one;
	logic signed [STATE_WIDTH-1:0] w_two;

	logic signed [SAMPLE_WIDTH-1:0] samples_to_send [$];
	filtered_t                      filtered_due [$];

	int   send_idle_pct = 18;
	int   recv_idle_pct = 88;
	int   holds_asked   = 0;
	int   holds_served  = 0;
	int   hold_left     = 0;
	logic in_took       = 1'b0;
	int   cycles        = 0;
	int   items_queued  = 0;
	int   items_in      = 0;
	int   results_out   = 0;
	int   clip_seen     = 0;
	int   mismatches    = 0;
	int   reg_writes    = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// exact sum at coefficient fraction, rounded half up onto the state grid
	function automatic longint round_half_up(input longint acc);
		return (acc + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
	endfunction

	function automatic longint saturate(input longint v, input int bits, inout logic hit);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (bits - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) begin
			hit = 1'b1;
			return hi;
		end
		if (v < lo) begin
			hit = 1'b1;
			return lo;
		end
		return v;
	endfunction

	task automatic filter_step(input logic signed [SAMPLE_WIDTH-1:0] x, output filtered_t res);
		longint w;
		longint y;
		logic   hit;
		hit = 1'b0;
		w = round_half_up((longint'(x) <<< COEF_FRAC)
			+ longint'(coef_model[REG_FEEDBACK_ONE]) * longint'(w_one)
			+ longint'(coef_model[REG_FEEDBACK_TWO]) * longint'(w_two));
		w = saturate(w, STATE_WIDTH, hit);
		y = round_half_up(longint'(coef_model[REG_FORWARD_ZERO]) * w
			+ longint'(coef_model[REG_FORWARD_ONE]) * longint'(w_one)
			+ longint'(coef_model[REG_FORWARD_TWO]) * longint'(w_two));
		y = saturate(y, SAMPLE_WIDTH, hit);
		w_two = w_one;
		w_one = STATE_WIDTH'(w);
		res.sample = SAMPLE_WIDTH'(y);
		res.clip = hit;
	endtask

	task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] index,
			input logic [COEF_WIDTH-1:0] value);
		@(negedge clk);
		cfg_write_en <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		// indexes past the last register are dropped by the block
		if (index < NUM_REGS) begin
			coef_model[index] = value;
		end
		reg_writes++;
		@(negedge clk);
		cfg_write_en <= 1'b0;
	endtask

	task automatic program_filter(input logic signed [COEF_WIDTH-1:0] a1,
			input logic signed [COEF_WIDTH-1:0] a2, input logic signed [COEF_WIDTH-1:0] b0,
			input logic signed [COEF_WIDTH-1:0] b1, input logic signed [COEF_WIDTH-1:0] b2);
		write_reg(REG_FEEDBACK_ONE, a1);
		write_reg(REG_FEEDBACK_TWO, a2);
		write_reg(REG_FORWARD_ZERO, b0);
		write_reg(REG_FORWARD_ONE, b1);
		write_reg(REG_FORWARD_TWO, b2);
	endtask

	function automatic logic signed [COEF_WIDTH-1:0] random_gain();
		return COEF_WIDTH'(int'($urandom_range(2 * UNITY)) - UNITY);
	endfunction

	// poles inside the unit circle: |a2| < 1 and |a1| < 1 - a2, with margin
	task automatic program_stable_filter();
		int a1;
		int a2;
		int span;
		a2 = int'($urandom_range(2 * (UNITY * 17 / 20))) - UNITY * 17 / 20;
		span = ((UNITY - a2) / 10) * 9;
		a1 = int'($urandom_range(2 * span)) - span;
		program_filter(COEF_WIDTH'(a1), COEF_WIDTH'(a2), random_gain(), random_gain(),
			random_gain());
	endtask

	task automatic program_random_filter();
		program_filter(COEF_WIDTH'($urandom()), COEF_WIDTH'($urandom()), COEF_WIDTH'($urandom()),
			COEF_WIDTH'($urandom()), COEF_WIDTH'($urandom()));
	endtask

	function automatic logic signed [SAMPLE_WIDTH-1:0] random_sample();
		int pick;
		pick = $urandom_range(99);
		if (pick < 6) begin
			return SAMPLE_MAX;
		end
		if (pick < 12) begin
			return SAMPLE_MIN;
		end
		if (pick < 22) begin
			return SAMPLE_WIDTH'(int'($urandom_range(8192)) - 4096);
		end
		return SAMPLE_WIDTH'($urandom());
	endfunction

	task automatic queue_sample(input logic signed [SAMPLE_WIDTH-1:0] s);
		samples_to_send.push_back(s);
		items_queued++;
	endtask

	// items_in moves at the rising edge, so checking at the falling edge is race free
	task automatic wait_idle();
		while (items_in != items_queued || filtered_due.size() != 0) begin
			@(negedge clk);
		end
	endtask

	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_took)) begin
			if (samples_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				sample_in <= samples_to_send.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (holds_served != holds_asked) begin
			holds_served <= holds_asked;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= arst_n && ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		filtered_t want;
		filtered_t got;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				filtered_due.size());
			$display("[FAIL] regression broken");
			$finish;
		end
		in_took <= in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall) begin
			filter_step(sample_in, want);
			filtered_due.push_back(want);
			items_in++;
		end
		if (arst_n && out_valid && !out_stall) begin
			results_out++;
			got.sample = sample_out;
			got.clip = clipped;
			if (clipped === 1'b1) begin
				clip_seen++;
			end
			if (filtered_due.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT) begin
					$display("%0t: unexpected item sample_out=%0d clipped=%b", $realtime,
						got.sample, got.clip);
				end
			end else begin
				want = filtered_due.pop_front();
				if (got.sample !== want.sample || got.clip !== want.clip) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT) begin
						$display("%0t: result %0d expected sample_out=%0d clipped=%b, got %0d %b",
							$realtime, results_out, want.sample, want.clip, got.sample, got.clip);
					end
				end
			end
		end
	end

	initial begin
		foreach (coef_model[k]) begin
			coef_model[k] = '0;
		end
		w_one = '0;
		w_two = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// coefficients out of reset are zero: silence regardless of input
		queue_sample(SAMPLE_MAX);
		queue_sample(SAMPLE_MIN);
		queue_sample('0);
		wait_idle();

		// writes past the last register must not land anywhere
		for (int k = NUM_REGS; k < (1 << CFG_INDEX_WIDTH); k++) begin
			write_reg(CFG_INDEX_WIDTH'(k), COEF_WIDTH'($urandom()) | COEF_WIDTH'(1));
		end
		queue_sample(SAMPLE_WIDTH'(1));
		queue_sample(SAMPLE_MAX);
		wait_idle();

		// unity pass-through, then half gain to hit rounding of odd samples
		program_filter('0, '0, COEF_ONE, '0, '0);
		queue_sample(SAMPLE_MAX);
		queue_sample(SAMPLE_MIN);
		queue_sample({(SAMPLE_WIDTH/2){2'b01}});
		queue_sample({(SAMPLE_WIDTH/2){2'b10}});
		queue_sample(SAMPLE_WIDTH'(1));
		queue_sample(SAMPLE_WIDTH'(-1));
		wait_idle();
		program_filter('0, '0, COEF_HALF, '0, '0);
		queue_sample(SAMPLE_WIDTH'(1));
		queue_sample(SAMPLE_WIDTH'(-1));
		queue_sample(SAMPLE_WIDTH'(3));
		wait_idle();

		// runaway feedback: state clamps high, then swings to clamp low
		program_filter(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MIN, COEF_MAX);
		repeat (4) queue_sample(SAMPLE_MAX);
		wait_idle();
		program_filter(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MAX, COEF_MIN);
		repeat (4) queue_sample(SAMPLE_MIN);
		wait_idle();

		for (int set = 0; set < 9; set++) begin
			case (set / 3)
				0: begin
					send_idle_pct = 18;
					recv_idle_pct = 88;
				end
				1: begin
					send_idle_pct = 88;
					recv_idle_pct = 18;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			if (set % 3 == 2) begin
				program_random_filter();
			end else begin
				program_stable_filter();
			end
			// long output hold while the sender keeps pushing
			if (set == 6) begin
				holds_asked++;
			end
			repeat (ITEMS_PER_SET) queue_sample(random_sample());
			wait_idle();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (filtered_due.size() != 0) begin
			$display("%0d results never arrived", filtered_due.size());
			mismatches += filtered_due.size();
		end
		$display("run covered %0d samples in, %0d results out (%0d clipped), %0d register writes",
			items_in, results_out, clip_seen, reg_writes);
		$display("three stall mixes, one %0d-cycle output hold, %0d mismatches", HOLD_CYCLES,
			mismatches);
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/bqd_pkg.sv
rtl/core/bqd_ctrl.sv
rtl/core/bqd_datapath.sv
rtl/core/biquad_direct_form_two_core.sv
rtl/core/bqd_checker.sv
verif/tb_biquad_direct_form_two_core.sv
